// ----- sv/ctgb_pkg.sv -----
// shared constants, codes and control/status types of the call trace graph builder
`timescale 1ns / 1ps
package ctgb_pkg;

  localparam int MAX_FUNCS   = 64;
  localparam int STACK_DEPTH = 64;
  localparam int KEY_BITS    = 32;

  localparam int FUNC_W  = $clog2(MAX_FUNCS);
  localparam int FCNT_W  = FUNC_W + 1;
  localparam int STK_W   = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = STK_W + 1;
  localparam int ROW_W   = FUNC_W + MAX_FUNCS;
  localparam int LIST_D  = MAX_FUNCS * MAX_FUNCS;

  localparam logic [1:0] CMD_ENTER  = 2'd0;
  localparam logic [1:0] CMD_RETURN = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TABLE_FULL = 3'd1;
  localparam logic [2:0] ST_STACK_FULL = 3'd2;
  localparam logic [2:0] ST_POP_EMPTY  = 3'd3;
  localparam logic [2:0] ST_RANGE      = 3'd4;

  typedef struct packed {
    logic       load;
    logic       look_next;
    logic       look_hit;
    logic       alloc;
    logic       set_err;
    logic [2:0] err_code;
    logic       caller_take;
    logic       edge_upd;
    logic       push;
    logic       pop;
    logic       llen_take;
    logic       key_rd;
    logic       ckey_take;
    logic       publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       depth_full;
    logic       depth_zero;
    logic       table_full;
    logic       count_zero;
    logic       key_match;
    logic       last_look;
    logic       caller_bad;
    logic       pos_out;
    logic       out_busy;
  } dp_stat_t;

endpackage

// ----- sv/ctgb_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ctgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/ctgb_ctrl.sv -----
// sequencing state machine of the call trace graph builder
`timescale 1ns / 1ps
module ctgb_ctrl import ctgb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DEC   = 13'b0000000000010,
    S_LRD   = 13'b0000000000100,
    S_LCMP  = 13'b0000000001000,
    S_ALLOC = 13'b0000000010000,
    S_CALL  = 13'b0000000100000,
    S_STK   = 13'b0000001000000,
    S_ROW   = 13'b0000010000000,
    S_PUSH  = 13'b0000100000000,
    S_RROW  = 13'b0001000000000,
    S_RLIST = 13'b0010000000000,
    S_RKEY  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.cmd)
          CMD_ENTER: begin
            if (stat.depth_full) begin
              cmd.set_err = 1'b1;
              cmd.err_code = ST_STACK_FULL;
              state_nxt = S_FIN;
            end else if (stat.count_zero) begin
              state_nxt = S_ALLOC;
            end else begin
              state_nxt = S_LCMP;
            end
          end
          CMD_RETURN: begin
            if (stat.depth_zero) begin
              cmd.set_err = 1'b1;
              cmd.err_code = ST_POP_EMPTY;
            end else begin
              cmd.pop = 1'b1;
            end
            state_nxt = S_FIN;
          end
          CMD_READ: begin
            if (stat.caller_bad) begin
              cmd.set_err = 1'b1;
              cmd.err_code = ST_RANGE;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_RROW;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_LRD: state_nxt = S_LCMP;
      S_LCMP: begin
        if (stat.key_match) begin
          cmd.look_hit = 1'b1;
          state_nxt = S_CALL;
        end else if (stat.last_look) begin
          state_nxt = S_ALLOC;
        end else begin
          cmd.look_next = 1'b1;
          state_nxt = S_LRD;
        end
      end
      S_ALLOC: begin
        if (stat.table_full) begin
          cmd.set_err = 1'b1;
          cmd.err_code = ST_TABLE_FULL;
          state_nxt = S_FIN;
        end else begin
          cmd.alloc = 1'b1;
          state_nxt = S_CALL;
        end
      end
      S_CALL: state_nxt = stat.depth_zero ? S_PUSH : S_STK;
      S_STK: begin
        cmd.caller_take = 1'b1;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.edge_upd = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        state_nxt = S_FIN;
      end
      S_RROW: begin
        cmd.llen_take = 1'b1;
        if (stat.pos_out) begin
          cmd.set_err = 1'b1;
          cmd.err_code = ST_RANGE;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RLIST;
        end
      end
      S_RLIST: begin
        cmd.key_rd = 1'b1;
        state_nxt = S_RKEY;
      end
      S_RKEY: begin
        cmd.ckey_take = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ----- sv/ctgb_dp.sv -----
// datapath: key table, frame stack, edge rows, edge lists and result register
`timescale 1ns / 1ps
module ctgb_dp import ctgb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  output dp_stat_t            stat,
  input  logic [1:0]          in_command,
  input  logic [31:0]         in_func_key,
  input  logic [5:0]          in_list_caller,
  input  logic [5:0]          in_list_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [5:0]          out_func_index,
  output logic [5:0]          out_caller_index,
  output logic                out_has_caller,
  output logic                out_new_edge,
  output logic [5:0]          out_callee_index,
  output logic [31:0]         out_callee_key,
  output logic [5:0]          out_list_length,
  output logic [6:0]          out_depth_now,
  output logic [6:0]          out_known_functions
);
  logic [1:0]          cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [FUNC_W-1:0]   lcaller_r, lpos_r, look_r, idx_r, caller_r, callee_r, llen_r;
  logic                has_caller_r, new_edge_r;
  logic [KEY_BITS-1:0] ckey_r;
  logic [2:0]          status_r;
  logic [FCNT_W-1:0]   fcount_r;
  logic [DEPTH_W-1:0]  depth_r;
  logic [MAX_FUNCS-1:0] row_vld_r;
  logic                out_valid_r;

  logic [KEY_BITS-1:0] key_rdata;
  logic [FUNC_W-1:0]   key_raddr;
  logic [FUNC_W-1:0]   stk_rdata;
  logic [ROW_W-1:0]    row_rdata, row_data, row_wdata;
  logic [FUNC_W-1:0]   row_raddr;
  logic [FUNC_W-1:0]   row_raddr_q;
  logic [FUNC_W-1:0]   list_rdata;
  logic [FUNC_W-1:0]   row_cnt;
  logic                edge_new;

  ctgb_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_FUNCS)) u_key (
    .clk(clk), .we(cmd.alloc), .waddr(fcount_r[FUNC_W-1:0]), .wdata(key_r),
    .raddr(key_raddr), .rdata(key_rdata));

  ctgb_ram #(.WIDTH(FUNC_W), .DEPTH(STACK_DEPTH)) u_stk (
    .clk(clk), .we(cmd.push), .waddr(depth_r[STK_W-1:0]), .wdata(idx_r),
    .raddr(STK_W'(depth_r - DEPTH_W'(1))), .rdata(stk_rdata));

  ctgb_ram #(.WIDTH(ROW_W), .DEPTH(MAX_FUNCS)) u_row (
    .clk(clk), .we(cmd.edge_upd && edge_new), .waddr(caller_r), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata));

  ctgb_ram #(.WIDTH(FUNC_W), .DEPTH(LIST_D)) u_list (
    .clk(clk), .we(cmd.edge_upd && edge_new), .waddr({caller_r, row_cnt}),
    .wdata(idx_r), .raddr({lcaller_r, lpos_r}), .rdata(list_rdata));

  assign key_raddr = cmd.key_rd ? list_rdata : look_r;
  assign row_raddr = cmd.caller_take ? stk_rdata : lcaller_r;
  assign row_data  = row_vld_r[row_raddr_q] ? row_rdata : '0;

  always_ff @(posedge clk) begin
    row_raddr_q <= row_raddr;
  end

  assign row_cnt  = row_data[ROW_W-1:MAX_FUNCS];
  assign edge_new = (caller_r != idx_r) && !row_data[idx_r];
  always_comb begin
    row_wdata = row_data;
    row_wdata[idx_r] = 1'b1;
    row_wdata[ROW_W-1:MAX_FUNCS] = row_cnt + FUNC_W'(1);
  end

  always_comb begin
    stat.cmd        = cmd_r;
    stat.depth_full = (depth_r == DEPTH_W'(STACK_DEPTH));
    stat.depth_zero = (depth_r == '0);
    stat.table_full = (fcount_r == FCNT_W'(MAX_FUNCS));
    stat.count_zero = (fcount_r == '0);
    stat.key_match  = (key_rdata == key_r);
    stat.last_look  = ({1'b0, look_r} + FCNT_W'(1)) == fcount_r;
    stat.caller_bad = ({1'b0, lcaller_r} >= fcount_r);
    stat.pos_out    = (lpos_r >= row_cnt);
    stat.out_busy   = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcount_r    <= '0;
      depth_r     <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.alloc) begin
        fcount_r <= fcount_r + FCNT_W'(1);
      end
      if (cmd.push) begin
        depth_r <= depth_r + DEPTH_W'(1);
      end else if (cmd.pop) begin
        depth_r <= depth_r - DEPTH_W'(1);
      end
      if (cmd.edge_upd && edge_new) begin
        row_vld_r[caller_r] <= 1'b1;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r        <= in_command;
      key_r        <= in_func_key[KEY_BITS-1:0];
      lcaller_r    <= in_list_caller;
      lpos_r       <= in_list_position;
      look_r       <= '0;
      idx_r        <= '0;
      caller_r     <= '0;
      callee_r     <= '0;
      llen_r       <= '0;
      has_caller_r <= 1'b0;
      new_edge_r   <= 1'b0;
      ckey_r       <= '0;
      status_r     <= ST_OK;
    end
    if (cmd.look_next) begin
      look_r <= look_r + FUNC_W'(1);
    end
    if (cmd.look_hit) begin
      idx_r <= look_r;
    end
    if (cmd.alloc) begin
      idx_r <= fcount_r[FUNC_W-1:0];
    end
    if (cmd.set_err) begin
      status_r <= cmd.err_code;
    end
    if (cmd.caller_take) begin
      caller_r     <= stk_rdata;
      has_caller_r <= 1'b1;
    end
    if (cmd.edge_upd && edge_new) begin
      new_edge_r <= 1'b1;
    end
    if (cmd.llen_take) begin
      llen_r <= row_cnt;
    end
    if (cmd.key_rd) begin
      callee_r <= list_rdata;
    end
    if (cmd.ckey_take) begin
      ckey_r <= key_rdata;
    end
    if (cmd.publish) begin
      out_status          <= status_r;
      out_func_index      <= idx_r;
      out_caller_index    <= caller_r;
      out_has_caller      <= has_caller_r;
      out_new_edge        <= new_edge_r;
      out_callee_index    <= callee_r;
      out_callee_key      <= 32'(ckey_r);
      out_list_length     <= llen_r;
      out_depth_now       <= 7'(depth_r);
      out_known_functions <= 7'(fcount_r);
    end
  end

  assign out_valid = out_valid_r;
endmodule

// ----- sv/call_trace_graph_builder_top.sv -----
// top level of the call trace graph builder
// builds a call graph from a trace of enter and return words.
// input channel: in_valid/in_ready with in_command (enter, return, read),
// in_func_key, in_list_caller and in_list_position.
// result channel: out_valid/out_ready, exactly one result word per input word.
// an enter looks its key up in the key table one entry at a time,
// assigns a new dense index on a miss, reads the stack top and the caller's
// edge row, records a new edge and pushes the callee. a read of an edge
// list entry goes through the row, list and key memory reads in turn.
// one word is worked on at a time; a new word is taken once the previous one
// has moved to the output register, so a waiting result does not hold the input.
// when the receiver stalls the result stays in the output register and the
// block stops before publishing the next result.
// reset clears the function count, stack depth and edge row valid bits at once;
// no clearing pass is needed.
`timescale 1ns / 1ps
module call_trace_graph_builder_top import ctgb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_func_key,
  input  logic [5:0]  in_list_caller,
  input  logic [5:0]  in_list_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_func_index,
  output logic [5:0]  out_caller_index,
  output logic        out_has_caller,
  output logic        out_new_edge,
  output logic [5:0]  out_callee_index,
  output logic [31:0] out_callee_key,
  output logic [5:0]  out_list_length,
  output logic [6:0]  out_depth_now,
  output logic [6:0]  out_known_functions
);
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ctgb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd));

  ctgb_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_command(in_command), .in_func_key(in_func_key),
    .in_list_caller(in_list_caller), .in_list_position(in_list_position),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_func_index(out_func_index), .out_caller_index(out_caller_index),
    .out_has_caller(out_has_caller), .out_new_edge(out_new_edge),
    .out_callee_index(out_callee_index), .out_callee_key(out_callee_key),
    .out_list_length(out_list_length), .out_depth_now(out_depth_now),
    .out_known_functions(out_known_functions));
endmodule
